>>> sv/tqle_pkg.sv
// ----------------------------------------------------------------------------
// tqle_pkg
// Shared types, register indexes and codes for the tabular Q-learning engine.
// ----------------------------------------------------------------------------
package tqle_pkg;

  localparam int unsigned STATES_DEF  = 4096;
  localparam int unsigned ACTIONS_DEF = 9;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned CFG_W       = 17;

  localparam logic [CFG_W-1:0] ONE_FRAC       = 17'd65536;
  localparam logic [CFG_W-1:0] LEARN_RATE_RST = 17'd6554;
  localparam logic [CFG_W-1:0] DISCOUNT_RST   = 17'd58982;

  localparam logic REG_LEARN_RATE = 1'b0;
  localparam logic REG_DISCOUNT   = 1'b1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_NO_LEGAL = 2'd2;

  localparam logic [1:0] OUT_SEL     = 2'd0;
  localparam logic [1:0] OUT_INVALID = 2'd1;
  localparam logic [1:0] OUT_UPDATE  = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [11:0]        state_index;
    logic [3:0]         action_index;
    logic signed [31:0] reward;
    logic [11:0]        next_state_index;
    logic [15:0]        legal_mask;
    logic               terminal;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         chosen_action;
    logic [1:0]         status;
    logic signed [31:0] q_value;
  } out_item_t;

  typedef struct packed {
    logic              load;
    logic              clr_we;
    logic              best_clr;
    logic              rd_en;
    logic              rd_act;
    logic [SLOT_W-1:0] rd_slot;
    logic              cmp_en;
    logic [SLOT_W-1:0] cmp_slot;
    logic              old_ld;
    logic              diff_ld;
    logic              prod2_ld;
    logic              wr_en;
    logic              out_ld;
    logic [1:0]        out_kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_select;
    logic act_invalid;
    logic terminal;
  } ctl_stat_t;

endpackage

>>> sv/tqle_ram.sv
// ----------------------------------------------------------------------------
// tqle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tqle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/tqle_dp.sv
// ----------------------------------------------------------------------------
// tqle_dp
// Datapath: item and config registers, row reduction, Q table, max scan,
// fixed-point update arithmetic and result register.
// ----------------------------------------------------------------------------
module tqle_dp #(
  parameter int unsigned STATES  = 4096,
  parameter int unsigned ACTIONS = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [16:0]         cfg_wdata,
  input  tqle_pkg::in_item_t  in_item,
  input  tqle_pkg::ctl_cmd_t  cmd,
  output tqle_pkg::ctl_stat_t stat,
  output tqle_pkg::out_item_t out_item
);

  import tqle_pkg::*;

  localparam int unsigned SW    = $clog2(STATES);
  localparam int unsigned DEPTH = STATES * (1 << SLOT_W);
  localparam int unsigned AW    = SW + SLOT_W;
  localparam logic [23:0] RECIP =
    24'(((64'd1 << 24) + 64'(STATES) - 64'd1) / 64'(STATES));
  localparam logic signed [37:0] NV_MAX = 38'sd2147483647;
  localparam logic signed [37:0] NV_MIN = -38'sd2147483648;

  in_item_t           item_r;
  logic [CFG_W-1:0]   learn_rate_r;
  logic [CFG_W-1:0]   discount_r;
  logic [CFG_W-1:0]   cfg_sat;
  logic [11:0]        q_row_r, q_nrow_r;
  logic [35:0]        q_row_prod, q_nrow_prod;
  logic [31:0]        row_rem, nrow_rem;
  logic [SW-1:0]      row_r, nrow_r;
  logic [AW-1:0]      clr_cnt_r;
  logic signed [31:0] best_r;
  logic [3:0]         best_act_r;
  logic               found_r;
  logic signed [31:0] old_r;
  logic signed [49:0] prod1_r;
  logic signed [34:0] diff_r;
  logic signed [52:0] prod2_r;
  out_item_t          out_r, out_nxt;

  logic [SW-1:0]      rd_row;
  logic [SLOT_W-1:0]  rd_slot;
  logic [AW-1:0]      raddr, waddr;
  logic [31:0]        wdata;
  logic [31:0]        rdata;
  logic signed [31:0] rq;
  logic signed [31:0] nmax;
  logic signed [49:0] r1_sum;
  logic signed [33:0] r1;
  logic signed [52:0] r2_sum;
  logic signed [37:0] r2;
  logic signed [37:0] nv_wide;
  logic signed [31:0] nv;

  // config
  assign cfg_sat = (cfg_wdata > ONE_FRAC) ? ONE_FRAC : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r <= LEARN_RATE_RST;
      discount_r   <= DISCOUNT_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_LEARN_RATE) begin
        learn_rate_r <= cfg_sat;
      end
      if (cfg_addr == REG_DISCOUNT) begin
        discount_r <= cfg_sat;
      end
    end
  end

  // item capture and row reduction modulo STATES (reciprocal multiply)
  assign q_row_prod  = 36'(item_r.state_index) * 36'(RECIP);
  assign q_nrow_prod = 36'(item_r.next_state_index) * 36'(RECIP);
  assign row_rem     = 32'(item_r.state_index) - 32'(q_row_r) * 32'(STATES);
  assign nrow_rem    = 32'(item_r.next_state_index) - 32'(q_nrow_r) * 32'(STATES);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    q_row_r  <= q_row_prod[35:24];
    q_nrow_r <= q_nrow_prod[35:24];
    row_r    <= row_rem[SW-1:0];
    nrow_r   <= nrow_rem[SW-1:0];
  end

  // clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Q table
  assign rd_row  = (cmd.rd_act || item_r.cmd == CMD_SELECT) ? row_r : nrow_r;
  assign rd_slot = cmd.rd_act ? item_r.action_index : cmd.rd_slot;
  assign raddr   = {rd_row, rd_slot};
  assign waddr   = cmd.clr_we ? clr_cnt_r : {row_r, item_r.action_index};
  assign wdata   = cmd.clr_we ? '0 : nv;

  tqle_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_qtab (
    .clk   (clk),
    .we    (cmd.clr_we | cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rq = signed'(rdata);

  // greedy max, lowest index wins ties
  always_ff @(posedge clk) begin
    if (cmd.best_clr) begin
      found_r    <= 1'b0;
      best_r     <= '0;
      best_act_r <= '0;
    end else if (cmd.cmp_en && item_r.legal_mask[cmd.cmp_slot] &&
                 (!found_r || rq > best_r)) begin
      found_r    <= 1'b1;
      best_r     <= rq;
      best_act_r <= cmd.cmp_slot;
    end
  end

  // update arithmetic
  assign nmax    = found_r ? best_r : '0;
  assign r1_sum  = prod1_r + 50'sd32768;
  assign r1      = 34'(r1_sum >>> 16);
  assign r2_sum  = prod2_r + 53'sd32768;
  assign r2      = 38'(r2_sum >>> 16);
  assign nv_wide = 38'(old_r) + r2;

  always_comb begin
    if (nv_wide > NV_MAX) begin
      nv = 32'sh7FFFFFFF;
    end else if (nv_wide < NV_MIN) begin
      nv = 32'sh80000000;
    end else begin
      nv = nv_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.old_ld) begin
      old_r   <= rq;
      prod1_r <= 50'(nmax) * 50'(signed'({1'b0, discount_r}));
    end
    if (cmd.diff_ld) begin
      diff_r <= 35'(item_r.reward) + 35'(r1) - 35'(old_r);
    end
    if (cmd.prod2_ld) begin
      prod2_r <= 53'(diff_r) * 53'(signed'({1'b0, learn_rate_r}));
    end
  end

  // result
  always_comb begin
    out_nxt = out_r;
    case (cmd.out_kind)
      OUT_SEL: begin
        if (found_r) begin
          out_nxt.chosen_action = best_act_r;
          out_nxt.status        = STATUS_OK;
          out_nxt.q_value       = best_r;
        end else begin
          out_nxt.chosen_action = '0;
          out_nxt.status        = STATUS_NO_LEGAL;
          out_nxt.q_value       = '0;
        end
      end
      OUT_INVALID: begin
        out_nxt.chosen_action = item_r.action_index;
        out_nxt.status        = STATUS_INVALID;
        out_nxt.q_value       = '0;
      end
      OUT_UPDATE: begin
        out_nxt.chosen_action = item_r.action_index;
        out_nxt.status        = STATUS_OK;
        out_nxt.q_value       = nv;
      end
      default: begin
        out_nxt = out_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_item         = out_r;
  assign stat.clr_done    = (clr_cnt_r == AW'(DEPTH - 1));
  assign stat.is_select   = (item_r.cmd == CMD_SELECT);
  assign stat.act_invalid = ({1'b0, item_r.action_index} >= 5'(ACTIONS));
  assign stat.terminal    = item_r.terminal;

endmodule

>>> sv/tqle_ctrl.sv
// ----------------------------------------------------------------------------
// tqle_ctrl
// Controller: clear sweep after reset, item sequencing and result strobe.
// ----------------------------------------------------------------------------
module tqle_ctrl #(
  parameter int unsigned ACTIONS = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tqle_pkg::ctl_stat_t stat,
  output tqle_pkg::ctl_cmd_t  cmd,
  output logic                out_valid
);

  import tqle_pkg::*;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_MODQ   = 4'd2;
  localparam logic [3:0] ST_MODR   = 4'd3;
  localparam logic [3:0] ST_SCAN   = 4'd4;
  localparam logic [3:0] ST_SCANL  = 4'd5;
  localparam logic [3:0] ST_SELOUT = 4'd6;
  localparam logic [3:0] ST_RDOLD  = 4'd7;
  localparam logic [3:0] ST_OLD    = 4'd8;
  localparam logic [3:0] ST_DIFF   = 4'd9;
  localparam logic [3:0] ST_MUL2   = 4'd10;
  localparam logic [3:0] ST_WRITE  = 4'd11;

  logic [3:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              cmp_v_r;
  logic [SLOT_W-1:0] cmp_slot_r;
  logic              out_valid_r;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.cmp_en   = cmp_v_r;
    cmd.cmp_slot = cmp_slot_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MODQ;
        end
      end
      ST_MODQ: begin
        state_nxt = ST_MODR;
      end
      ST_MODR: begin
        cmd.best_clr = 1'b1;
        cnt_nxt      = '0;
        if (!stat.is_select && stat.act_invalid) begin
          cmd.out_ld   = 1'b1;
          cmd.out_kind = OUT_INVALID;
          state_nxt    = ST_IDLE;
        end else if (!stat.is_select && stat.terminal) begin
          state_nxt = ST_RDOLD;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_slot = cnt_r;
        cnt_nxt     = cnt_r + SLOT_W'(1);
        if (cnt_r == SLOT_W'(ACTIONS - 1)) begin
          state_nxt = ST_SCANL;
        end
      end
      ST_SCANL: begin
        if (stat.is_select) begin
          state_nxt = ST_SELOUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_act = 1'b1;
          state_nxt  = ST_OLD;
        end
      end
      ST_SELOUT: begin
        cmd.out_ld   = 1'b1;
        cmd.out_kind = OUT_SEL;
        state_nxt    = ST_IDLE;
      end
      ST_RDOLD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_act = 1'b1;
        state_nxt  = ST_OLD;
      end
      ST_OLD: begin
        cmd.old_ld = 1'b1;
        state_nxt  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_ld = 1'b1;
        state_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.prod2_ld = 1'b1;
        state_nxt    = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr_en    = 1'b1;
        cmd.out_ld   = 1'b1;
        cmd.out_kind = OUT_UPDATE;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      cmp_v_r     <= 1'b0;
      cmp_slot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_v_r     <= (state_r == ST_SCAN);
      cmp_slot_r  <= cnt_r;
      out_valid_r <= cmd.out_ld;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> sv/tabular_q_learning_engine_top.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_engine_top
// Q-table update and greedy action select on a STATES x 16 table of Q16.16.
//
// After reset the engine sweeps all STATES*16 table entries to zero, one entry
// per cycle (65536 entries at the defaults); busy stays high until then.
// A request is taken when start is high and busy is low; one request is in
// flight at a time and its result shows on out_item for exactly one cycle
// with out_valid, which the receiver must take. A select runs the row
// reduction and the max scan of its row; an update scans the next row,
// reads the old entry, runs the two registered multiplies and writes back;
// a terminal update skips the scan and an invalid action ends after the row
// reduction. The single table read port reads one slot per cycle in the scan.
// ----------------------------------------------------------------------------
module tabular_q_learning_engine_top #(
  parameter int unsigned STATES  = tqle_pkg::STATES_DEF,
  parameter int unsigned ACTIONS = tqle_pkg::ACTIONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tqle_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tqle_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [16:0]         cfg_wdata
);

  import tqle_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  tqle_ctrl #(
    .ACTIONS (ACTIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .stat      (stat),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  tqle_dp #(
    .STATES  (STATES),
    .ACTIONS (ACTIONS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == STATUS_INVALID |-> out_item.q_value == 32'sd0)
    else $error("invalid action result carries a value");
`endif

endmodule

>>> verif/q_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_engine_checker
// Watches the request, result and register ports of the Q-learning engine.
// It keeps its own Q table and rate registers, works out the result of every
// accepted request, and compares each result strobe field by field with the
// oldest prediction. It reports the running failure count and the number of
// results still due.
// ----------------------------------------------------------------------------
module q_engine_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  tqle_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  tqle_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [16:0]         cfg_wdata,
  output int                  fail_count,
  output int                  pending_count
);
  import tqle_pkg::*;

  localparam int ROWS  = STATES_DEF;
  localparam int ACT_N = ACTIONS_DEF;
  localparam int SLOTS = 16;

  logic signed [31:0] q_table [ROWS*SLOTS];
  int                 alpha_frac;
  int                 gamma_frac;
  out_item_t          predicted_responses[$];
  int                 err_total = 0;

  function automatic int clamp_frac(logic [16:0] v);
    return (v > ONE_FRAC) ? int'(ONE_FRAC) : int'(v);
  endfunction

  // floor((p + 0.5) in Q16): round to nearest, ties up
  function automatic longint round_q16(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic bit greedy_scan(int row, logic [15:0] mask,
                                     output logic [3:0] act,
                                     output logic signed [31:0] val);
    bit found;
    found = 1'b0;
    act   = '0;
    val   = '0;
    for (int a = 0; a < ACT_N; a++) begin
      if (mask[a] && (!found || q_table[row*SLOTS+a] > val)) begin
        val   = q_table[row*SLOTS+a];
        act   = 4'(a);
        found = 1'b1;
      end
    end
    return found;
  endfunction

  function automatic out_item_t predict_response(in_item_t r);
    out_item_t          res;
    int                 row;
    int                 slot;
    logic [15:0]        mask;
    logic [3:0]         act;
    logic signed [31:0] best;
    longint             old_q;
    longint             target;
    longint             nv;
    row  = int'(r.state_index) % ROWS;
    mask = r.legal_mask & 16'((1 << ACT_N) - 1);
    res  = '0;
    if (r.cmd == CMD_SELECT) begin
      if (greedy_scan(row, mask, act, best)) begin
        res.chosen_action = act;
        res.status        = STATUS_OK;
        res.q_value       = best;
      end else begin
        res.status = STATUS_NO_LEGAL;
      end
      return res;
    end
    res.chosen_action = r.action_index;
    if (r.action_index >= ACT_N) begin
      res.status = STATUS_INVALID;
      return res;
    end
    slot   = row*SLOTS + int'(r.action_index);
    old_q  = longint'(q_table[slot]);
    target = longint'($signed(r.reward));
    if (!r.terminal) begin
      if (!greedy_scan(int'(r.next_state_index) % ROWS, mask, act, best))
        best = '0;
      target += round_q16(longint'(best) * longint'(gamma_frac));
    end
    nv = old_q + round_q16((target - old_q) * longint'(alpha_frac));
    if (nv > 64'sd2147483647)
      nv = 64'sd2147483647;
    if (nv < -64'sd2147483648)
      nv = -64'sd2147483648;
    q_table[slot] = nv[31:0];
    res.status    = STATUS_OK;
    res.q_value   = nv[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < ROWS*SLOTS; i++)
        q_table[i] = '0;
      alpha_frac = int'(LEARN_RATE_RST);
      gamma_frac = int'(DISCOUNT_RST);
      predicted_responses.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_LEARN_RATE)
          alpha_frac = clamp_frac(cfg_wdata);
        else
          gamma_frac = clamp_frac(cfg_wdata);
      end
      if (out_valid) begin
        if (predicted_responses.size() == 0) begin
          $error("result with no request outstanding: action %0d status %0d q %0d",
                 out_item.chosen_action, out_item.status, $signed(out_item.q_value));
          err_total++;
        end else begin
          want = predicted_responses.pop_front();
          if (out_item.chosen_action !== want.chosen_action) begin
            $error("chosen_action mismatch: expected %0d, actual %0d",
                   want.chosen_action, out_item.chosen_action);
            err_total++;
          end
          if (out_item.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_item.status);
            err_total++;
          end
          if (out_item.q_value !== want.q_value) begin
            $error("q_value mismatch: expected %0d, actual %0d",
                   $signed(want.q_value), $signed(out_item.q_value));
            err_total++;
          end
        end
      end
      if (start && !busy)
        predicted_responses.push_back(predict_response(in_item));
    end
    fail_count    <= err_total;
    pending_count <= predicted_responses.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the tabular Q-learning engine.
// Directed requests cover empty and out-of-range masks, invalid actions,
// terminal and bootstrapped updates, ties and saturation at both ends; then
// phases of random requests run under varied learning and discount rates,
// mostly on a small pool of rows so that updates feed later reads.
// ----------------------------------------------------------------------------
module testbench;
  import tqle_pkg::*;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 230;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we;
  logic        cfg_addr;
  logic [16:0] cfg_wdata;
  int          fail_count;
  int          pending_count;
  bit          no_gap;

  tabular_q_learning_engine_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  q_engine_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic in_item_t req(logic cmd, logic [11:0] s, logic [3:0] a,
                                   logic [31:0] rew, logic [11:0] ns,
                                   logic [15:0] mask, logic term);
    in_item_t r;
    r.cmd              = cmd;
    r.state_index      = s;
    r.action_index     = a;
    r.reward           = rew;
    r.next_state_index = ns;
    r.legal_mask       = mask;
    r.terminal         = term;
    return r;
  endfunction

  // narrow: 16 rows at both ends of the table, so entries get reused
  function automatic logic [11:0] pick_row(bit wide);
    logic hi;
    hi = 1'($urandom_range(0, 1));
    if (wide)
      return 12'($urandom_range(0, 4095));
    return {{9{hi}}, 3'($urandom_range(0, 7))};
  endfunction

  function automatic logic [16:0] pick_frac();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ONE_FRAC;
      2:       return 17'h1FFFF;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic in_item_t random_request(bit wide);
    in_item_t r;
    r.cmd              = ($urandom_range(0, 9) < 3) ? CMD_SELECT : CMD_UPDATE;
    r.state_index      = pick_row(wide);
    r.next_state_index = pick_row(wide);
    r.action_index     = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 8));
    case ($urandom_range(0, 7))
      0:       r.reward = $urandom;
      1:       r.reward = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: r.reward = 32'($urandom_range(0, 1048576)) - 32'd524288;
    endcase
    case ($urandom_range(0, 7))
      0:       r.legal_mask = '0;
      1:       r.legal_mask = 16'hFFFF;
      2:       r.legal_mask = 16'(1 << $urandom_range(0, 15));
      default: r.legal_mask = 16'($urandom);
    endcase
    r.terminal = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  task automatic send(in_item_t r);
    int gap;
    if ($urandom_range(0, 39) == 0)
      no_gap = !no_gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0 || busy);
  endtask

  task automatic set_rates(logic [16:0] lr, logic [16:0] disc);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_LEARN_RATE;
    cfg_wdata <= lr;
    @(posedge clk);
    cfg_addr  <= REG_DISCOUNT;
    cfg_wdata <= disc;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    bit wide;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_LEARN_RATE;
    cfg_wdata = '0;
    no_gap    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset rates
    send(req(CMD_SELECT, 12'd0, 4'd0, 32'd0, 12'd0, 16'h0000, 1'b0));
    send(req(CMD_SELECT, 12'd0, 4'd0, 32'd0, 12'd0, 16'hFFFF, 1'b0));
    send(req(CMD_SELECT, 12'd0, 4'd0, 32'd0, 12'd0, 16'hFE00, 1'b0));
    send(req(CMD_UPDATE, 12'd0, 4'd9, 32'h00010000, 12'd5, 16'hFFFF, 1'b0));
    send(req(CMD_UPDATE, 12'd0, 4'd15, 32'h7FFFFFFF, 12'd0, 16'hFFFF, 1'b1));
    send(req(CMD_UPDATE, 12'd0, 4'd0, 32'h7FFFFFFF, 12'd0, 16'h0000, 1'b1));
    send(req(CMD_UPDATE, 12'd0, 4'd1, 32'h80000000, 12'hABC, 16'hFFFF, 1'b1));
    send(req(CMD_UPDATE, 12'd1, 4'd2, 32'h00010000, 12'd0, 16'hFFFF, 1'b0));
    send(req(CMD_UPDATE, 12'd1, 4'd3, 32'hFFFFFFFB, 12'd0, 16'h0000, 1'b0));
    send(req(CMD_UPDATE, 12'd1, 4'd4, 32'd0, 12'd0, 16'h0002, 1'b0));
    send(req(CMD_UPDATE, 12'hFFF, 4'd8, 32'h00012345, 12'hFFF, 16'h0100, 1'b0));
    send(req(CMD_SELECT, 12'd0, 4'd7, 32'h1234, 12'd9, 16'h0003, 1'b1));
    send(req(CMD_SELECT, 12'd1, 4'd0, 32'd0, 12'd0, 16'h01FF, 1'b0));
    send(req(CMD_SELECT, 12'hFFF, 4'd0, 32'd0, 12'd0, 16'hFFFF, 1'b0));

    // full rates; learn rate above one saturates
    drain();
    set_rates(17'h1FFFF, ONE_FRAC);
    send(req(CMD_UPDATE, 12'd2, 4'd0, 32'h7FFFFFFF, 12'd0, 16'h0000, 1'b1));
    send(req(CMD_UPDATE, 12'd2, 4'd0, 32'h7FFFFFFF, 12'd2, 16'h0001, 1'b0));
    send(req(CMD_UPDATE, 12'd3, 4'd5, 32'h80000000, 12'd0, 16'h0000, 1'b1));
    send(req(CMD_UPDATE, 12'd3, 4'd5, 32'h80000000, 12'd3, 16'h0020, 1'b0));
    send(req(CMD_SELECT, 12'd2, 4'd0, 32'd0, 12'd0, 16'h0101, 1'b0));
    send(req(CMD_SELECT, 12'd3, 4'd0, 32'd0, 12'd0, 16'h0020, 1'b0));
    send(req(CMD_SELECT, 12'd3, 4'd0, 32'd0, 12'd0, 16'h01FF, 1'b0));

    // zero rates: nothing moves
    drain();
    set_rates('0, '0);
    send(req(CMD_UPDATE, 12'd2, 4'd0, 32'h80000000, 12'd2, 16'hFFFF, 1'b0));
    send(req(CMD_SELECT, 12'd2, 4'd0, 32'd0, 12'd0, 16'h0001, 1'b0));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       set_rates(LEARN_RATE_RST, DISCOUNT_RST);
        1:       set_rates('0, ONE_FRAC);
        2:       set_rates(ONE_FRAC, '0);
        default: set_rates(pick_frac(), pick_frac());
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 0 && k % 25 == 24)
          drain();
        wide = ($urandom_range(0, 7) == 0);
        send(random_request(wide));
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
